/* src/sxof_pkg.sv */
// shared types and constants for the sic/xe operand fetch block
package sxof_pkg;

    // field widths
    localparam int unsigned WORD_W      = 24;
    localparam int unsigned INSTR_W     = 32;
    localparam int unsigned MADDR_W     = 16;
    localparam int unsigned DISP_W      = 23;
    localparam int unsigned TA_W        = 25;
    localparam int unsigned SUM_W       = 27;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned OUT_TDATA_W = 96;

    // input tdata layout
    localparam int unsigned IN_INSTR_LO = 0;
    localparam int unsigned IN_LONG_BIT = 32;
    localparam int unsigned IN_MADDR_LO = 33;
    localparam int unsigned IN_MDATA_LO = 49;

    // output tdata layout
    localparam int unsigned OUT_AMODE_LO = 13;
    localparam int unsigned OUT_REL_LO   = 16;
    localparam int unsigned OUT_TA_LO    = 41;
    localparam int unsigned OUT_OPND_LO  = 66;
    localparam int unsigned OUT_FAULT    = 91;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX = 2'd2;

    // register reset values
    localparam logic [WORD_W-1:0] BASE_RESET  = 24'h006000;
    localparam logic [WORD_W-1:0] PC_RESET    = 24'h003000;
    localparam logic [WORD_W-1:0] INDEX_RESET = 24'h000090;

    typedef enum logic [1:0] {
        AMODE_SIMPLE    = 2'd0,
        AMODE_INDIRECT  = 2'd1,
        AMODE_IMMEDIATE = 2'd2
    } t_amode;

    typedef enum logic [1:0] {
        REL_DIRECT = 2'd0,
        REL_BASE   = 2'd1,
        REL_PC     = 2'd2
    } t_rel;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic take_in;
        logic calc;
        logic rd1;
        logic rd2;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_write;
        logic need_rd2;
    } t_dp_sts;

endpackage

/* src/sxof_ctrl.sv */
// controller state machine: memory clearing pass, item sequencing, output hold
module sxof_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sxof_pkg::t_dp_cmd o_cmd,
    input  sxof_pkg::t_dp_sts i_sts
);
    import sxof_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_READ,
        S_READ2,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_take;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_take      = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.take_in  = w_take;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.rd1      = (r_state == S_READ);
        o_cmd.rd2      = (r_state == S_READ2);
        o_cmd.load_out = (r_state == S_FIN) && w_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.in_write ? S_FIN : S_CALC;
            end
            S_CALC:  n_state = S_READ;
            S_READ:  n_state = i_sts.need_rd2 ? S_READ2 : S_FIN;
            S_READ2: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/sxof_datapath.sv */
// datapath: decode, target address adder, word memory and result register
module sxof_datapath #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [sxof_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sxof_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic [sxof_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                                i_in_user,
    output logic [sxof_pkg::OUT_TDATA_W-1:0]    o_out_data,
    input  sxof_pkg::t_dp_cmd                   i_cmd,
    output sxof_pkg::t_dp_sts                   o_sts
);
    import sxof_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    // configuration registers
    logic [WORD_W-1:0] r_base, r_pc, r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_pc    <= PC_RESET;
            r_index <= INDEX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_PC:    r_pc    <= i_cfg_data;
                CFG_INDEX: r_index <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // input beat fields
    logic [INSTR_W-1:0] w_instr;
    logic               w_long;
    logic [MADDR_W-1:0] w_maddr;
    logic [WORD_W-1:0]  w_mdata;

    assign w_instr = i_in_data[IN_INSTR_LO +: INSTR_W];
    assign w_long  = i_in_data[IN_LONG_BIT];
    assign w_maddr = i_in_data[IN_MADDR_LO +: MADDR_W];
    assign w_mdata = i_in_data[IN_MDATA_LO +: WORD_W];

    // instruction decode
    logic [5:0]        w_opc, w_flags;
    logic              w_sic, w_fmt4;
    t_amode            w_amode;
    t_rel              w_rel;
    logic [DISP_W-1:0] w_disp;
    logic [SUM_W-1:0]  w_disp_sx, w_part;

    always_comb begin
        w_opc   = w_long ? w_instr[31:26] : w_instr[23:18];
        w_flags = w_long ? w_instr[25:20] : w_instr[17:12];
        w_sic   = !w_flags[5] && !w_flags[4];
        w_fmt4  = !w_sic && w_flags[0];
        if (w_sic) begin
            w_disp = w_long ? w_instr[22:0] : {8'd0, w_instr[14:0]};
        end else begin
            w_disp = w_long ? {3'd0, w_instr[19:0]} : {11'd0, w_instr[11:0]};
        end
        if (w_sic || (w_flags[5] && w_flags[4])) w_amode = AMODE_SIMPLE;
        else if (w_flags[5]) w_amode = AMODE_INDIRECT;
        else w_amode = AMODE_IMMEDIATE;
        w_rel = REL_DIRECT;
        if (!w_sic && !w_flags[0]) begin
            if (w_flags[2]) w_rel = REL_BASE;
            else if (w_flags[1]) w_rel = REL_PC;
        end
        // pc-relative field is a signed 12 or 20 bit offset
        w_disp_sx = w_long ? {{(SUM_W-20){w_instr[19]}}, w_instr[19:0]}
                           : {{(SUM_W-12){w_instr[11]}}, w_instr[11:0]};
        case (w_rel)
            REL_PC:   w_part = w_disp_sx + {{(SUM_W-WORD_W){1'b0}}, r_pc};
            REL_BASE: w_part = {{(SUM_W-DISP_W){1'b0}}, w_disp}
                               + {{(SUM_W-WORD_W){1'b0}}, r_base};
            default:  w_part = {{(SUM_W-DISP_W){1'b0}}, w_disp};
        endcase
    end

    // decoded item registers
    logic [5:0]        r_opc, r_flags;
    logic              r_sic, r_fmt4, r_is_write;
    t_amode            r_amode;
    t_rel              r_rel;
    logic [DISP_W-1:0] r_disp;
    logic [SUM_W-1:0]  r_part;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_opc      <= w_opc;
            r_flags    <= w_flags;
            r_sic      <= w_sic;
            r_fmt4     <= w_fmt4;
            r_amode    <= w_amode;
            r_rel      <= w_rel;
            r_disp     <= w_disp;
            r_part     <= w_part;
            r_is_write <= !i_in_user;
        end
    end

    // index add and range checks
    logic [SUM_W-1:0] w_ta;
    logic             w_neg, w_oor;
    logic [SUM_W-1:0] r_ta;
    logic             r_neg, r_oor;

    assign w_ta  = r_part + (r_flags[3] ? {{(SUM_W-WORD_W){1'b0}}, r_index} : '0);
    assign w_neg = w_ta[SUM_W-1];
    assign w_oor = (w_ta[SUM_W-2:0] >> ADDR_BITS) != '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_ta  <= w_ta;
            r_neg <= w_neg;
            r_oor <= w_oor;
        end
    end

    // clearing pass counter
    logic [ADDR_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
    end

    // word memory, one write and one registered read port
    logic [WORD_W-1:0]    r_mem [0:DEPTH-1];
    logic [WORD_W-1:0]    r_rd_data;
    logic                 w_we, w_re, w_wr_ok, w_ptr_oor, w_need_rd2;
    logic [ADDR_BITS-1:0] w_waddr, w_raddr;
    logic [WORD_W-1:0]    w_wdata;
    logic [31:0]          w_maddr_ext;

    assign w_maddr_ext = 32'(w_maddr);
    assign w_wr_ok     = (w_maddr_ext >> ADDR_BITS) == '0;
    assign w_we        = i_cmd.clr_step || (i_cmd.take_in && !i_in_user && w_wr_ok);
    assign w_waddr     = i_cmd.clr_step ? r_clr_addr : ADDR_BITS'(w_maddr);
    assign w_wdata     = i_cmd.clr_step ? '0 : w_mdata;
    assign w_ptr_oor   = (r_rd_data >> ADDR_BITS) != '0;
    assign w_need_rd2  = (r_amode == AMODE_INDIRECT) && !r_neg && !r_oor && !w_ptr_oor;
    assign w_re        = i_cmd.calc || (i_cmd.rd1 && w_need_rd2);
    assign w_raddr     = i_cmd.calc ? w_ta[ADDR_BITS-1:0] : r_rd_data[ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rd_data <= r_mem[w_raddr];
    end

    // operand and fault
    logic [TA_W-1:0] w_ta_out;
    logic [TA_W-1:0] r_opnd;
    logic            r_fault;

    assign w_ta_out = r_neg ? '0 : r_ta[TA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd1) begin
            case (r_amode)
                AMODE_IMMEDIATE: begin
                    r_opnd  <= w_ta_out;
                    r_fault <= r_neg;
                end
                AMODE_INDIRECT: begin
                    r_opnd  <= '0;
                    r_fault <= r_neg || r_oor || w_ptr_oor;
                end
                default: begin
                    r_opnd  <= (r_neg || r_oor) ? '0 : {1'b0, r_rd_data};
                    r_fault <= r_neg || r_oor;
                end
            endcase
        end else if (i_cmd.rd2) begin
            r_opnd <= {1'b0, r_rd_data};
        end
    end

    // result register
    logic [OUT_TDATA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_is_write) r_out <= '0;
            else r_out <= {4'd0, r_fault, r_opnd, w_ta_out, r_disp, r_rel, r_fmt4,
                           r_amode, r_sic, r_flags, r_opc};
        end
    end

    assign o_out_data     = r_out;
    assign o_sts.clr_last = &r_clr_addr;
    assign o_sts.in_write = !i_in_user;
    assign o_sts.need_rd2 = w_need_rd2;

endmodule

/* src/sic_xe_operand_fetch.sv */
// top level of the sic/xe target address and operand fetch block
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tdata (instr, mem write), tuser (command)
//  m_axis    out        tvalid / tready           tdata (decode, address, operand)
//  cfg       in         valid / ready (always 1)  index, data
//
// an instruction passes the calc, read and fin states from accept to result,
// with a second read state for indirect, whose two word memory reads are
// dependent; a memory write goes straight to fin. one item is in flight at a time.
// after reset a clearing pass zeroes every word of the memory, during
// which no beat is accepted; config writes are taken at any time.
// a stalled result waits in the output register; the following result is not
// loaded until that stalled result has been taken.
module sic_xe_operand_fetch #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // instr_word[31:0], long_form[32], mem_address[48:33], mem_data[72:49]
    input  logic [sxof_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // command[0]
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // opcode_bits[5:0], flag_bits[11:6], is_plain_sic[12], address_mode[14:13],
    // is_format_four[15], relative_mode[17:16], displacement[40:18],
    // target_address[65:41], operand_value[90:66], range_fault[91]
    output logic [sxof_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sxof_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sxof_pkg::WORD_W-1:0]          i_cfg_data
);
    import sxof_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencing
    sxof_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // decode, address and memory
    sxof_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

/* src/sxof_chk.sv */
// port-level checker for the operand fetch block, bound to the top level
module sxof_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [sxof_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import sxof_pkg::*;

    logic [1:0]      w_amode, w_rel;
    logic [TA_W-1:0] w_ta, w_opnd;
    logic            w_fault;

    assign w_amode = o_m_axis_tdata[OUT_AMODE_LO +: 2];
    assign w_rel   = o_m_axis_tdata[OUT_REL_LO +: 2];
    assign w_ta    = o_m_axis_tdata[OUT_TA_LO +: TA_W];
    assign w_opnd  = o_m_axis_tdata[OUT_OPND_LO +: TA_W];
    assign w_fault = o_m_axis_tdata[OUT_FAULT];

    // one item at a time: no accept on the cycle after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result beat changed while stalled");

    // a fault always reads zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_fault) |-> (w_opnd == '0))
        else $error("faulting result carries a nonzero operand");

    // immediate operand is the target address
    a_imm_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_amode == AMODE_IMMEDIATE)) |-> (w_opnd == w_ta))
        else $error("immediate operand differs from target address");

    // mode codes stay within their defined values
    a_mode_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_amode != 2'd3) && (w_rel != 2'd3)))
        else $error("undefined addressing or relative mode code");

endmodule

bind sic_xe_operand_fetch sxof_chk u_sxof_chk (.*);
